// ----- sv/cdr_pkg.sv -----
`default_nettype none
package cdr_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 4096;
   localparam int FRAC_BITS   = 16;
   localparam int ROW_LEN     = MAX_WIDTH + 2;
   localparam int STORE_DEPTH = 2 * ROW_LEN;
   localparam int COL_W       = $clog2(ROW_LEN);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = 13;
   localparam int WORD_W      = 128;
   localparam int PADDR_W     = 5;
   // holds every intermediate of the stencil exactly
   localparam int WIDE_W      = 68 - FRAC_BITS;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic [COL_W-1:0]         col_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [ROW_W-1:0]         row_type;

   localparam wide_type Q_MAX = (wide_type'(1) <<< 31) - wide_type'(1);
   localparam wide_type Q_MIN = -(wide_type'(1) <<< 31);

   typedef struct packed {
      col_type     w2;
      row_type     h2;
      logic [30:0] dx;
      logic [30:0] dy;
      logic [30:0] dxdy;
      logic [30:0] dydx;
      logic [30:0] vol;
   } cfg_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      logic     src_rd;
      logic     src_wr;
      col_type  src_addr;
   } store_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_FLUX, ST_COEF, ST_AP, ST_TERM, ST_OUT, ST_WRITE
   } state_type;

   typedef enum logic [2:0] {
      REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_CELL_DX, REG_CELL_DY,
      REG_DX_OVER_DY, REG_DY_OVER_DX, REG_CELL_VOLUME
   } reg_index_type;

endpackage
`default_nettype wire

// ----- sv/cdr_req_if.sv -----
`default_nettype none
interface cdr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temp;
   logic signed [31:0] source;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] visc;

   modport src (output valid, temp, source, vel_x, vel_y, visc, input ready);
   modport sink (input valid, temp, source, vel_x, vel_y, visc, output ready);
endinterface
`default_nettype wire

// ----- sv/cdr_rsp_if.sv -----
`default_nettype none
interface cdr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] residual;
   logic [8:0]         cell_col;
   logic [12:0]        cell_row;
   logic               saturated;
   logic               last_cell;

   modport src (output valid, residual, cell_col, cell_row, saturated, last_cell,
                input ready);
   modport sink (input valid, residual, cell_col, cell_row, saturated, last_cell,
                 output ready);
endinterface
`default_nettype wire

// ----- sv/convection_diffusion_residual_stencil.sv -----
`default_nettype none
// channel   dir  handshake      payload
// req_port  in   valid/ready    temp, source, vel_x, vel_y, visc (Q16.16 signed)
// rsp_port  out  valid/ready    residual, cell_col, cell_row, saturated, last_cell
// apb       in   psel/penable   7 registers at 4*i, pready tied high
//
// a halo point is accepted, then written to the store
// an interior point takes 4 line store reads and a source read, 14 products on the
// one shared multiplier, the coefficient and ap steps, output, write
// a result waits in the output register while the next point is taken
// synchronous active-high reset clears the counters and control; the line stores
// are not cleared
module convection_diffusion_residual_stencil import cdr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   cdr_req_if.sink            req_port,
   cdr_rsp_if.src             rsp_port,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [2:0] READ_LAST = 3'd4;
   localparam logic [2:0] FLUX_LAST = 3'd7;
   localparam logic [2:0] TERM_LAST = 3'd5;

   cfg_type       cfg;
   store_cmd_type cmd;
   logic [WORD_W-1:0] rd_word;
   logic [31:0]       src_rd_data;

   state_type state_ff, state_in;
   col_type   col_ff, col_in;
   row_type   row_ff, row_in;
   logic [2:0] idx_ff, idx_in;
   logic       issued_ff, issued_in;

   // point under work
   col_type   c_ff;
   row_type   r_ff;
   logic      last_ff;
   logic signed [31:0] in_temp_ff, in_src_ff, in_vx_ff, in_vy_ff, in_nu_ff;
   logic signed [31:0] tw_ff, tp_ff, te_ff, ts_ff;
   logic signed [31:0] uw_ff, up_ff, ue_ff, vp_ff, vs_ff;
   logic signed [31:0] nw_ff, np_ff, ne_ff, ns_ff, src_ff;
   wide_type  f_ff [8];
   wide_type  a_ff [4];
   wide_type  fsum_ff, sum_ff;
   logic [30:0] coefq_ff [4];
   logic signed [31:0] ap_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_res_ff;
   col_type            rsp_col_ff;
   row_type            rsp_row_ff;
   logic               rsp_sat_ff, rsp_last_ff;

   // accept-time coordinates
   col_type   c0;
   row_type   r0, rn;
   logic [COL_W:0] c1;
   logic      interior, accept, out_load, mul_start, mul_done;
   logic signed [32:0] mul_x;
   logic signed [31:0] mul_y;
   logic signed [64:0] mul_prod;
   wide_type  ap_full, term;

   function automatic addr_type row_addr(input logic bank, input col_type c);
      row_addr = bank ? addr_type'(c) + addr_type'(ROW_LEN) : addr_type'(c);
   endfunction

   function automatic wide_type max3(input wide_type a, input wide_type b,
                                     input wide_type c);
      wide_type m;
      m = (a > b) ? a : b;
      max3 = (m > c) ? m : c;
   endfunction

   cdr_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   cdr_store u_store (
      .clock(clock), .cmd(cmd),
      .wr_word({in_temp_ff, in_vx_ff, in_vy_ff, in_nu_ff}),
      .src_wr_data(in_src_ff), .rd_word(rd_word), .src_rd_data(src_rd_data)
   );

   cdr_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .x(mul_x), .y(mul_y),
      .done(mul_done), .prod(mul_prod)
   );

   assign accept = req_port.valid && req_port.ready;

   // counters wrap first against the current sizes, then advance
   always_comb begin
      c0 = col_ff;
      r0 = row_ff;
      if (col_ff >= cfg.w2) begin
         c0 = '0;
         r0 = row_ff + 13'd1;
      end
      if (r0 >= cfg.h2) r0 = '0;
      interior = (r0 >= 13'd2) && (c0 != '0) && (c0 < cfg.w2 - col_type'(1));
      c1 = {1'b0, c0} + (COL_W+1)'(1);
      rn = r0 + 13'd1;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c1 >= {1'b0, cfg.w2}) begin
            col_in = '0;
            row_in = (rn >= cfg.h2) ? '0 : rn;
         end else begin
            col_in = c1[COL_W-1:0];
            row_in = r0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_port.valid) state_in = interior ? ST_READ : ST_WRITE;
         ST_READ:  if (idx_ff == READ_LAST) state_in = ST_FLUX;
         ST_FLUX:  if (mul_done && idx_ff == FLUX_LAST) state_in = ST_COEF;
         ST_COEF:  state_in = ST_AP;
         ST_AP:    state_in = ST_TERM;
         ST_TERM:  if (mul_done && idx_ff == TERM_LAST) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_port.ready) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // fsm outputs: store commands, multiplier start, output load
   always_comb begin
      req_port.ready = 1'b0;
      cmd            = '0;
      cmd.src_addr   = c_ff;
      mul_start      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE: req_port.ready = 1'b1;
         ST_READ: begin
            cmd.rd_en = (idx_ff != READ_LAST);
            case (idx_ff)
               3'd0: begin
                  cmd.rd_addr = row_addr(~r_ff[0], c_ff - col_type'(1));
                  cmd.src_rd  = 1'b1;
               end
               3'd1:    cmd.rd_addr = row_addr(~r_ff[0], c_ff);
               3'd2:    cmd.rd_addr = row_addr(~r_ff[0], c_ff + col_type'(1));
               default: cmd.rd_addr = row_addr(r_ff[0], c_ff);
            endcase
         end
         ST_FLUX, ST_TERM: mul_start = !issued_ff;
         ST_OUT: out_load = !rsp_valid_ff || rsp_port.ready;
         ST_WRITE: begin
            // new point replaces the row two back
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = row_addr(r_ff[0], c_ff);
            cmd.src_wr  = 1'b1;
         end
         default: ;
      endcase
   end

   // step counter and multiplier handshake
   always_comb begin
      idx_in    = idx_ff;
      issued_in = issued_ff;
      if (state_in != state_ff) begin
         idx_in    = 3'd0;
         issued_in = 1'b0;
      end else if (state_ff == ST_READ) begin
         idx_in = idx_ff + 3'd1;
      end else if (state_ff == ST_FLUX || state_ff == ST_TERM) begin
         if (!issued_ff) issued_in = 1'b1;
         else if (mul_done) begin
            issued_in = 1'b0;
            idx_in    = idx_ff + 3'd1;
         end
      end
   end

   // multiplier operands: face fluxes and diffusion, then the residual terms
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      if (state_ff == ST_FLUX) begin
         case (idx_ff)
            3'd0: begin mul_x = 33'(vs_ff) + 33'(vp_ff);    mul_y = {1'b0, cfg.dx};   end
            3'd1: begin mul_x = 33'(in_vy_ff) + 33'(vp_ff); mul_y = {1'b0, cfg.dx};   end
            3'd2: begin mul_x = 33'(ue_ff) + 33'(up_ff);    mul_y = {1'b0, cfg.dy};   end
            3'd3: begin mul_x = 33'(uw_ff) + 33'(up_ff);    mul_y = {1'b0, cfg.dy};   end
            3'd4: begin mul_x = 33'(np_ff) + 33'(ns_ff);    mul_y = {1'b0, cfg.dxdy}; end
            3'd5: begin mul_x = 33'(np_ff) + 33'(in_nu_ff); mul_y = {1'b0, cfg.dxdy}; end
            3'd6: begin mul_x = 33'(np_ff) + 33'(ne_ff);    mul_y = {1'b0, cfg.dydx}; end
            default: begin mul_x = 33'(np_ff) + 33'(nw_ff); mul_y = {1'b0, cfg.dydx}; end
         endcase
      end else begin
         case (idx_ff)
            3'd0: begin mul_x = {2'b00, cfg.vol};      mul_y = src_ff;     end
            3'd1: begin mul_x = {2'b00, coefq_ff[0]};  mul_y = ts_ff;      end
            3'd2: begin mul_x = {2'b00, coefq_ff[1]};  mul_y = in_temp_ff; end
            3'd3: begin mul_x = {2'b00, coefq_ff[2]};  mul_y = te_ff;      end
            3'd4: begin mul_x = {2'b00, coefq_ff[3]};  mul_y = tw_ff;      end
            default: begin mul_x = 33'(ap_ff);         mul_y = tp_ff;      end
         endcase
      end
   end

   assign ap_full = fsum_ff + a_ff[0] + a_ff[1] + a_ff[2] + a_ff[3];
   assign term    = WIDE_W'(mul_prod >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ff       <= 3'd0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         idx_ff    <= idx_in;
         issued_ff <= issued_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_port.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_temp_ff <= req_port.temp;
         in_src_ff  <= req_port.source;
         in_vx_ff   <= req_port.vel_x;
         in_vy_ff   <= req_port.vel_y;
         in_nu_ff   <= req_port.visc;
         c_ff       <= c0;
         r_ff       <= r0;
         last_ff    <= (c0 == cfg.w2 - col_type'(2)) && (r0 == cfg.h2 - 13'd1);
      end
      // read data lands in the cycle after its address
      if (state_ff == ST_READ) begin
         case (idx_ff)
            3'd1: begin
               tw_ff  <= rd_word[127:96];
               uw_ff  <= rd_word[95:64];
               nw_ff  <= rd_word[31:0];
               src_ff <= src_rd_data;
            end
            3'd2: begin
               tp_ff <= rd_word[127:96];
               up_ff <= rd_word[95:64];
               vp_ff <= rd_word[63:32];
               np_ff <= rd_word[31:0];
            end
            3'd3: begin
               te_ff <= rd_word[127:96];
               ue_ff <= rd_word[95:64];
               ne_ff <= rd_word[31:0];
            end
            3'd4: begin
               ts_ff <= rd_word[127:96];
               vs_ff <= rd_word[63:32];
               ns_ff <= rd_word[31:0];
            end
            default: ;
         endcase
      end
      if (state_ff == ST_FLUX && mul_done)
         f_ff[idx_ff] <= WIDE_W'(mul_prod >>> (FRAC_BITS + 1));
      // hybrid coefficients: fs fn fe fw at 0..3, ds dn de dw at 4..7
      if (state_ff == ST_COEF) begin
         a_ff[0] <= max3(f_ff[0], f_ff[4] + (f_ff[0] >>> 1), '0);
         a_ff[1] <= max3(-f_ff[1], f_ff[5] - (f_ff[1] >>> 1), '0);
         a_ff[2] <= max3(-f_ff[2], f_ff[6] - (f_ff[2] >>> 1), '0);
         a_ff[3] <= max3(f_ff[3], f_ff[7] + (f_ff[3] >>> 1), '0);
         fsum_ff <= f_ff[2] - f_ff[3] + f_ff[1] - f_ff[0];
      end
      if (state_ff == ST_AP) begin
         for (int i = 0; i < 4; i++)
            coefq_ff[i] <= (a_ff[i] > Q_MAX) ? 31'h7FFF_FFFF : a_ff[i][30:0];
         if (ap_full > Q_MAX) ap_ff <= 32'sh7FFF_FFFF;
         else if (ap_full < Q_MIN) ap_ff <= 32'sh8000_0000;
         else ap_ff <= ap_full[31:0];
         sum_ff <= '0;
      end
      if (state_ff == ST_TERM && mul_done)
         sum_ff <= (idx_ff == TERM_LAST) ? sum_ff - term : sum_ff + term;
      if (out_load) begin
         rsp_col_ff  <= c_ff;
         rsp_row_ff  <= r_ff - 13'd1;
         rsp_last_ff <= last_ff;
         rsp_sat_ff  <= (sum_ff > Q_MAX) || (sum_ff < Q_MIN);
         if (sum_ff > Q_MAX) rsp_res_ff <= 32'sh7FFF_FFFF;
         else if (sum_ff < Q_MIN) rsp_res_ff <= 32'sh8000_0000;
         else rsp_res_ff <= sum_ff[31:0];
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.residual  = rsp_res_ff;
   assign rsp_port.cell_col  = 9'(rsp_col_ff);
   assign rsp_port.cell_row  = rsp_row_ff;
   assign rsp_port.saturated = rsp_sat_ff;
   assign rsp_port.last_cell = rsp_last_ff;

   // an accepted item always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item left the sequencer idle");

   // multiplier results only arrive while a product phase waits for them
   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_FLUX || state_ff == ST_TERM))
      else $error("multiplier finished outside a product phase");

   // results come only from interior rows
   a_row_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0))
      else $error("result carries a halo row");

endmodule
`default_nettype wire

// ----- sv/cdr_csr.sv -----
`default_nettype none
module cdr_csr import cdr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [8:0]    gw_ff;
   logic [12:0]   gh_ff;
   logic [30:0]   dx_ff, dy_ff, dxdy_ff, dydx_ff, vol_ff;
   logic          wr;
   reg_index_type idx;
   logic [8:0]    eff_w;
   logic [12:0]   eff_h;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[PADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff   <= 9'(MAX_WIDTH);
         gh_ff   <= 13'd256;
         dx_ff   <= 31'(1 << FRAC_BITS);
         dy_ff   <= 31'(1 << FRAC_BITS);
         dxdy_ff <= 31'(1 << FRAC_BITS);
         dydx_ff <= 31'(1 << FRAC_BITS);
         vol_ff  <= 31'(1 << FRAC_BITS);
      end else if (wr) begin
         case (idx)
            REG_GRID_WIDTH:  gw_ff   <= pwdata[8:0];
            REG_GRID_HEIGHT: gh_ff   <= pwdata[12:0];
            REG_CELL_DX:     dx_ff   <= pwdata[30:0];
            REG_CELL_DY:     dy_ff   <= pwdata[30:0];
            REG_DX_OVER_DY:  dxdy_ff <= pwdata[30:0];
            REG_DY_OVER_DX:  dydx_ff <= pwdata[30:0];
            REG_CELL_VOLUME: vol_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_GRID_WIDTH:  prdata = {23'd0, gw_ff};
         REG_GRID_HEIGHT: prdata = {19'd0, gh_ff};
         REG_CELL_DX:     prdata = {1'b0, dx_ff};
         REG_CELL_DY:     prdata = {1'b0, dy_ff};
         REG_DX_OVER_DY:  prdata = {1'b0, dxdy_ff};
         REG_DY_OVER_DX:  prdata = {1'b0, dydx_ff};
         REG_CELL_VOLUME: prdata = {1'b0, vol_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // zero acts as one, oversize clamps to the store size
   always_comb begin
      eff_w = gw_ff;
      if (gw_ff == 9'd0) eff_w = 9'd1;
      else if (gw_ff > 9'(MAX_WIDTH)) eff_w = 9'(MAX_WIDTH);
      eff_h = gh_ff;
      if (gh_ff == 13'd0) eff_h = 13'd1;
      else if (gh_ff > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
   end

   assign cfg.w2   = col_type'(eff_w) + col_type'(2);
   assign cfg.h2   = eff_h + 13'd2;
   assign cfg.dx   = dx_ff;
   assign cfg.dy   = dy_ff;
   assign cfg.dxdy = dxdy_ff;
   assign cfg.dydx = dydx_ff;
   assign cfg.vol  = vol_ff;

endmodule
`default_nettype wire

// ----- sv/cdr_store.sv -----
`default_nettype none
module cdr_store import cdr_pkg::*; (
   input  logic               clock,
   input  store_cmd_type      cmd,
   input  logic [WORD_W-1:0]  wr_word,
   input  logic [31:0]        src_wr_data,
   output logic [WORD_W-1:0]  rd_word,
   output logic [31:0]        src_rd_data
);

   // two rows of {temp, vel_x, vel_y, visc}, one row of source
   logic [WORD_W-1:0] rows_mem [STORE_DEPTH];
   logic [31:0]       src_mem  [ROW_LEN];
   logic [WORD_W-1:0] rd_word_ff;
   logic [31:0]       src_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) rows_mem[cmd.wr_addr] <= wr_word;
      if (cmd.rd_en) rd_word_ff <= rows_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.src_wr) src_mem[cmd.src_addr] <= src_wr_data;
      else if (cmd.src_rd) src_rd_ff <= src_mem[cmd.src_addr];
   end

   assign rd_word     = rd_word_ff;
   assign src_rd_data = src_rd_ff;

endmodule
`default_nettype wire

// ----- sv/cdr_mul.sv -----
`default_nettype none
module cdr_mul import cdr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] x,
   input  logic signed [31:0] y,
   output logic               done,
   output logic signed [64:0] prod
);

   // exact product from a 33x17 and a 33x16 partial product
   logic [1:0]         phase_ff, phase_in;
   logic               done_ff;
   logic signed [32:0] x_ff;
   logic signed [31:0] y_ff;
   logic signed [49:0] pp_ff, pp_in;
   logic signed [64:0] acc_ff, acc_in;
   logic signed [16:0] lo_s;
   logic signed [15:0] hi_s;

   assign lo_s = {1'b0, y_ff[15:0]};
   assign hi_s = y_ff[31:16];

   always_comb begin
      phase_in = phase_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         2'd0: if (start) phase_in = 2'd1;
         2'd1: begin
            pp_in    = 50'(x_ff) * 50'(lo_s);
            phase_in = 2'd2;
         end
         2'd2: begin
            acc_in   = 65'(pp_ff);
            pp_in    = 50'(x_ff) * 50'(hi_s);
            phase_in = 2'd3;
         end
         default: begin
            acc_in   = acc_ff + (65'(pp_ff) <<< 16);
            phase_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= (phase_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == 2'd0 && start) begin
         x_ff <= x;
         y_ff <= y;
      end
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire
